// ===== design/jsu_pkg.sv =====
package jsu_pkg;

   // status codes carried with every result word
   localparam logic [2:0] ST_RUNNING      = 3'd0;
   localparam logic [2:0] ST_CLOSED       = 3'd1;
   localparam logic [2:0] ST_CONTROL      = 3'd2;
   localparam logic [2:0] ST_BAD_ESCAPE   = 3'd3;
   localparam logic [2:0] ST_BAD_HEX      = 3'd4;
   localparam logic [2:0] ST_BAD_SURR     = 3'd5;
   localparam logic [2:0] ST_UNTERMINATED = 3'd6;
   localparam logic [2:0] ST_IDLE         = 3'd7;

   // ascii bytes of interest
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5c;
   localparam logic [7:0] CH_SLASH     = 8'h2f;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_N         = 8'h6e;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_U         = 8'h75;
   localparam logic [7:0] CH_SPACE     = 8'h20;

   // up to four decoded bytes from one input word
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [1:0]      last_idx;
   } utf8_type;

   // everything one input word produces, handed to the output stage
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [1:0]      last_idx;
      logic            byte_valid;
      logic [2:0]      status;
   } bundle_type;

   // hex digit value, top bit set when the byte is a hex digit
   function automatic logic [4:0] hex_of(input logic [7:0] b);
      logic [4:0] r;
      r = '0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

   // utf-8 encoding of a code point up to 21 bits
   function automatic utf8_type utf8_encode(input logic [20:0] cp);
      utf8_type r;
      r = '0;
      if (cp <= 21'h7f) begin
         r.data[0]  = cp[7:0];
         r.last_idx = 2'd0;
      end else if (cp <= 21'h7ff) begin
         r.data[0]  = {3'b110, cp[10:6]};
         r.data[1]  = {2'b10, cp[5:0]};
         r.last_idx = 2'd1;
      end else if (cp <= 21'hffff) begin
         r.data[0]  = {4'b1110, cp[15:12]};
         r.data[1]  = {2'b10, cp[11:6]};
         r.data[2]  = {2'b10, cp[5:0]};
         r.last_idx = 2'd2;
      end else begin
         r.data[0]  = {5'b11110, cp[20:18]};
         r.data[1]  = {2'b10, cp[17:12]};
         r.data[2]  = {2'b10, cp[11:6]};
         r.data[3]  = {2'b10, cp[5:0]};
         r.last_idx = 2'd3;
      end
      return r;
   endfunction

endpackage

// ===== design/jsu_decode.sv =====
module jsu_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic [7:0]          data_byte,
   input  logic                start_string,
   input  logic                end_of_input,
   output jsu_pkg::bundle_type bundle
);

   localparam logic [2:0] MODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_BODY   = 3'd1;
   localparam logic [2:0] MODE_ESC    = 3'd2;
   localparam logic [2:0] MODE_HEX1   = 3'd3;
   localparam logic [2:0] MODE_EXP_BS = 3'd4;
   localparam logic [2:0] MODE_EXP_U  = 3'd5;
   localparam logic [2:0] MODE_HEX2   = 3'd6;

   logic [2:0]  mode_ff, mode_in;
   logic [15:0] hex_ff, hex_in;
   logic [1:0]  count_ff, count_in;
   logic [9:0]  surr_ff, surr_in;

   logic [4:0]        hex_digit;
   logic [15:0]       hex_next;
   logic              emit_byte;
   logic              emit_cp;
   logic [7:0]        single;
   logic [20:0]       cp;
   logic [2:0]        status;
   jsu_pkg::utf8_type enc;

   assign hex_digit = jsu_pkg::hex_of(data_byte);
   assign hex_next  = {hex_ff[11:0], hex_digit[3:0]};

   // next decode state and what this word gives out
   always_comb begin
      mode_in   = mode_ff;
      hex_in    = hex_ff;
      count_in  = count_ff;
      surr_in   = surr_ff;
      emit_byte = 1'b0;
      emit_cp   = 1'b0;
      single    = data_byte;
      cp        = {5'd0, hex_next};
      status    = jsu_pkg::ST_RUNNING;

      if (start_string) begin
         hex_in   = '0;
         count_in = '0;
         surr_in  = '0;
         if (data_byte == jsu_pkg::CH_QUOTE) begin
            mode_in = MODE_BODY;
         end else begin
            mode_in = MODE_IDLE;
            status  = jsu_pkg::ST_IDLE;
         end
      end else begin
         unique case (mode_ff) inside
            MODE_BODY: begin
               if (data_byte == jsu_pkg::CH_QUOTE) begin
                  mode_in = MODE_IDLE;
                  status  = jsu_pkg::ST_CLOSED;
               end else if (data_byte < jsu_pkg::CH_SPACE) begin
                  mode_in = MODE_IDLE;
                  status  = jsu_pkg::ST_CONTROL;
               end else if (data_byte == jsu_pkg::CH_BACKSLASH) begin
                  mode_in = MODE_ESC;
               end else begin
                  emit_byte = 1'b1;
               end
            end
            MODE_ESC: begin
               mode_in = MODE_BODY;
               case (data_byte) inside
                  jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_SLASH: begin
                     emit_byte = 1'b1;
                  end
                  jsu_pkg::CH_B: begin
                     emit_byte = 1'b1;
                     single    = 8'h08;
                  end
                  jsu_pkg::CH_F: begin
                     emit_byte = 1'b1;
                     single    = 8'h0c;
                  end
                  jsu_pkg::CH_N: begin
                     emit_byte = 1'b1;
                     single    = 8'h0a;
                  end
                  jsu_pkg::CH_R: begin
                     emit_byte = 1'b1;
                     single    = 8'h0d;
                  end
                  jsu_pkg::CH_T: begin
                     emit_byte = 1'b1;
                     single    = 8'h09;
                  end
                  jsu_pkg::CH_U: begin
                     mode_in  = MODE_HEX1;
                     hex_in   = '0;
                     count_in = '0;
                  end
                  default: begin
                     mode_in = MODE_IDLE;
                     status  = jsu_pkg::ST_BAD_ESCAPE;
                  end
               endcase
            end
            MODE_HEX1, MODE_HEX2: begin
               if (!hex_digit[4]) begin
                  mode_in = MODE_IDLE;
                  status  = jsu_pkg::ST_BAD_HEX;
               end else if (count_ff != 2'd3) begin
                  hex_in   = hex_next;
                  count_in = count_ff + 2'd1;
               end else begin
                  count_in = '0;
                  hex_in   = '0;
                  if (mode_ff == MODE_HEX1) begin
                     if (hex_next[15:10] == 6'b110110) begin
                        // high surrogate, wait for its partner
                        surr_in = hex_next[9:0];
                        mode_in = MODE_EXP_BS;
                     end else if (hex_next[15:10] == 6'b110111) begin
                        mode_in = MODE_IDLE;
                        status  = jsu_pkg::ST_BAD_SURR;
                     end else begin
                        emit_cp = 1'b1;
                        mode_in = MODE_BODY;
                     end
                  end else begin
                     if (hex_next[15:10] == 6'b110111) begin
                        // combine the pair into one code point
                        cp      = 21'h10000 + {1'b0, surr_ff, hex_next[9:0]};
                        emit_cp = 1'b1;
                        surr_in = '0;
                        mode_in = MODE_BODY;
                     end else begin
                        mode_in = MODE_IDLE;
                        status  = jsu_pkg::ST_BAD_SURR;
                     end
                  end
               end
            end
            MODE_EXP_BS: begin
               if (data_byte == jsu_pkg::CH_BACKSLASH) begin
                  mode_in = MODE_EXP_U;
               end else begin
                  mode_in = MODE_IDLE;
                  status  = jsu_pkg::ST_BAD_SURR;
               end
            end
            MODE_EXP_U: begin
               if (data_byte == jsu_pkg::CH_U) begin
                  mode_in  = MODE_HEX2;
                  hex_in   = '0;
                  count_in = '0;
               end else begin
                  mode_in = MODE_IDLE;
                  status  = jsu_pkg::ST_BAD_SURR;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
               status  = jsu_pkg::ST_IDLE;
            end
         endcase
         if (mode_in == MODE_IDLE) begin
            hex_in   = '0;
            count_in = '0;
            surr_in  = '0;
         end
      end

      // input ends with a literal still open
      if (end_of_input && mode_in != MODE_IDLE) begin
         mode_in  = MODE_IDLE;
         hex_in   = '0;
         count_in = '0;
         surr_in  = '0;
         status   = jsu_pkg::ST_UNTERMINATED;
      end
   end

   assign enc = jsu_pkg::utf8_encode(cp);

   // result bundle for the output stage
   always_comb begin
      bundle            = '0;
      bundle.status     = status;
      bundle.byte_valid = emit_byte | emit_cp;
      if (emit_cp) begin
         bundle.data     = enc.data;
         bundle.last_idx = enc.last_idx;
      end else if (emit_byte) begin
         bundle.data[0] = single;
      end
   end

   // decode state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         hex_ff   <= '0;
         count_ff <= '0;
         surr_ff  <= '0;
      end else if (load) begin
         mode_ff  <= mode_in;
         hex_ff   <= hex_in;
         count_ff <= count_in;
         surr_ff  <= surr_in;
      end
   end

endmodule

// ===== design/jsu_out.sv =====
module jsu_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  jsu_pkg::bundle_type bundle,
   output logic                free,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata,
   output logic                rsp_tlast,
   output logic                rsp_tuser
);

   logic                valid_ff;
   jsu_pkg::bundle_type held_ff;
   logic [1:0]          idx_ff;
   logic                take;
   logic                last;

   assign last = (idx_ff == held_ff.last_idx);
   assign take = valid_ff & rsp_tready;
   assign free = ~valid_ff | (take & last);

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'd0, held_ff.status, held_ff.data[idx_ff]};
   assign rsp_tlast  = last;
   assign rsp_tuser  = held_ff.byte_valid;

   // control: bundle held and word index within it
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (take) begin
         if (last) begin
            valid_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (load) begin
         held_ff <= bundle;
      end
   end

endmodule

// ===== design/json_string_unescaper.sv =====
// JSON string literal decoder: feed the raw text one byte per word, with
// req_tuser set on the opening quote of each literal and req_tlast on the
// final byte of the input; the block returns the decoded UTF-8 bytes, each
// word carrying the status after that input byte in rsp_tdata[10:8] and
// rsp_tlast marking the last result of an input byte. An input byte that
// gives no decoded byte still returns one word with rsp_tuser low. Input
// bytes giving at most one result are taken one per cycle while rsp_tready is
// high; the single result register hands out the up to four UTF-8 bytes of a
// completed \u escape in turn and takes no new input byte until the last is out.
module json_string_unescaper (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_input
   input  logic        req_tuser,   // start_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [10:8] status, rest zero
   output logic        rsp_tlast,   // run_last
   output logic        rsp_tuser    // byte_valid
);

   logic                load;
   logic                free;
   jsu_pkg::bundle_type bundle;

   assign req_tready = free;
   assign load       = req_tvalid & free;

   // byte decoder and escape state
   jsu_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .load         (load),
      .data_byte    (req_tdata),
      .start_string (req_tuser),
      .end_of_input (req_tlast),
      .bundle       (bundle)
   );

   // result register and byte sequencer
   jsu_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .bundle     (bundle),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== tb/sv/json_string_unescaper_tb.sv =====
`timescale 1ns / 1ps

module json_string_unescaper_tb;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 300;
   localparam int PHASE_WORDS    = 143;

   // decoder modes of the prediction
   typedef enum logic [3:0] {
      DM_IDLE, DM_BODY, DM_ESC, DM_HEX1, DM_EXP_BS, DM_EXP_U, DM_HEX2
   } decode_mode_type;

   typedef struct {
      logic [7:0] data;
      logic       start;
      logic       eoi;
      logic       drain_first;
   } text_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      logic [2:0] status;
   } utf8_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] data_byte
   logic        req_tlast = 1'b0; // end_of_input
   logic        req_tuser = 1'b0; // start_string
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [7:0] out_byte, [10:8] status, rest zero
   logic        rsp_tlast;        // run_last
   logic        rsp_tuser;        // byte_valid

   text_word_type text_pending[$];
   utf8_word_type utf8_expected[$];
   logic [7:0]    decoded_bytes[$];

   // predicted decoder state
   decode_mode_type dmode = DM_IDLE;
   logic [15:0]     hex_acc = '0;
   logic [1:0]      hex_cnt = '0;
   logic [9:0]      hi_surr = '0;

   int n_words_queued = 0;
   int n_req_offered  = 0;
   int n_req_taken    = 0;
   int n_rsp_taken    = 0;
   int n_errors       = 0;
   int quiet_cycles   = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int hold_asked     = 0;
   int status_seen[8] = '{default: 0};

   json_string_unescaper DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // value of a hex digit in either case, -1 otherwise
   function automatic int nibble_of(input logic [7:0] c);
      logic [7:0] folded;
      folded = c | 8'h20;
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (folded >= "a" && folded <= "f") return int'(folded - "a") + 10;
      return -1;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
   endfunction

   task automatic clear_decoder();
      dmode   = DM_IDLE;
      hex_acc = '0;
      hex_cnt = '0;
      hi_surr = '0;
   endtask

   // one more decoded byte of the current text byte
   task automatic note_byte(input logic [7:0] b);
      decoded_bytes.insert(decoded_bytes.size(), b);
   endtask

   // utf-8 bytes of one code point, lead byte first
   task automatic add_code_point(input int unsigned cp);
      int nb;
      nb = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
      if (nb == 1) begin
         note_byte(cp[7:0]);
      end else begin
         note_byte((8'hff << (8 - nb)) | 8'(cp >> (6 * (nb - 1))));
         for (int i = nb - 2; i >= 0; i--)
            note_byte(8'h80 | 8'((cp >> (6 * i)) & 'h3f));
      end
   endtask

   // work out the result words of one accepted text byte
   task automatic decode_text_byte(input logic [7:0] b, input logic start,
                                   input logic eoi);
      logic [2:0]    st;
      int            nib;
      utf8_word_type w;
      st = jsu_pkg::ST_RUNNING;
      decoded_bytes.delete();
      if (start) begin
         clear_decoder();
         if (b == jsu_pkg::CH_QUOTE) dmode = DM_BODY;
         else st = jsu_pkg::ST_IDLE;
      end else begin
         case (dmode)
            DM_BODY: begin
               if (b == jsu_pkg::CH_QUOTE) begin
                  clear_decoder();
                  st = jsu_pkg::ST_CLOSED;
               end else if (b < jsu_pkg::CH_SPACE) begin
                  clear_decoder();
                  st = jsu_pkg::ST_CONTROL;
               end else if (b == jsu_pkg::CH_BACKSLASH) begin
                  dmode = DM_ESC;
               end else begin
                  note_byte(b);
               end
            end
            DM_ESC: begin
               dmode = DM_BODY;
               case (b)
                  jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_SLASH: note_byte(b);
                  jsu_pkg::CH_B: note_byte(8'h08);
                  jsu_pkg::CH_F: note_byte(8'h0c);
                  jsu_pkg::CH_N: note_byte(8'h0a);
                  jsu_pkg::CH_R: note_byte(8'h0d);
                  jsu_pkg::CH_T: note_byte(8'h09);
                  jsu_pkg::CH_U: begin
                     dmode   = DM_HEX1;
                     hex_acc = '0;
                     hex_cnt = '0;
                  end
                  default: begin
                     clear_decoder();
                     st = jsu_pkg::ST_BAD_ESCAPE;
                  end
               endcase
            end
            DM_HEX1, DM_HEX2: begin
               nib = nibble_of(b);
               if (nib < 0) begin
                  clear_decoder();
                  st = jsu_pkg::ST_BAD_HEX;
               end else begin
                  hex_acc = {hex_acc[11:0], 4'(nib)};
                  if (hex_cnt != 2'd3) begin
                     hex_cnt++;
                  end else begin
                     hex_cnt = '0;
                     if (dmode == DM_HEX1) begin
                        if (hex_acc >= 16'hd800 && hex_acc <= 16'hdbff) begin
                           // high half of a pair, wait for the low half
                           hi_surr = hex_acc[9:0];
                           hex_acc = '0;
                           dmode   = DM_EXP_BS;
                        end else if (hex_acc >= 16'hdc00 && hex_acc <= 16'hdfff) begin
                           clear_decoder();
                           st = jsu_pkg::ST_BAD_SURR;
                        end else begin
                           add_code_point(32'(hex_acc));
                           hex_acc = '0;
                           dmode   = DM_BODY;
                        end
                     end else if (hex_acc >= 16'hdc00 && hex_acc <= 16'hdfff) begin
                        add_code_point(32'h10000 + {hi_surr, hex_acc[9:0]});
                        hex_acc = '0;
                        hi_surr = '0;
                        dmode   = DM_BODY;
                     end else begin
                        clear_decoder();
                        st = jsu_pkg::ST_BAD_SURR;
                     end
                  end
               end
            end
            DM_EXP_BS: begin
               if (b == jsu_pkg::CH_BACKSLASH) begin
                  dmode = DM_EXP_U;
               end else begin
                  clear_decoder();
                  st = jsu_pkg::ST_BAD_SURR;
               end
            end
            DM_EXP_U: begin
               if (b == jsu_pkg::CH_U) begin
                  dmode   = DM_HEX2;
                  hex_acc = '0;
                  hex_cnt = '0;
               end else begin
                  clear_decoder();
                  st = jsu_pkg::ST_BAD_SURR;
               end
            end
            default: begin
               clear_decoder();
               st = jsu_pkg::ST_IDLE;
            end
         endcase
      end
      // an open literal at the end of the input is an error
      if (eoi && dmode != DM_IDLE) begin
         clear_decoder();
         st = jsu_pkg::ST_UNTERMINATED;
      end
      if (decoded_bytes.size() == 0) begin
         w = '{out_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b1, status: st};
         utf8_expected.insert(utf8_expected.size(), w);
      end else begin
         foreach (decoded_bytes[i]) begin
            w = '{out_byte: decoded_bytes[i], byte_valid: 1'b1,
                  run_last: (i == decoded_bytes.size() - 1), status: st};
            utf8_expected.insert(utf8_expected.size(), w);
         end
      end
   endtask

   // text word driver, one word per handshake
   always @(negedge clock) begin
      text_word_type w;
      if (!reset && (!req_tvalid || n_req_taken == n_req_offered)) begin
         if (text_pending.size() != 0 &&
             !(text_pending[0].drain_first && utf8_expected.size() != 0) &&
             $urandom_range(99) >= send_idle_pct) begin
            w = text_pending.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= w.data;
            req_tuser  <= w.start;
            req_tlast  <= w.eoi;
            n_req_offered++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result receiver with random stalls and the long hold-off
   always @(negedge clock) begin
      static int hold_left = 0;
      static int hold_seen = 0;
      if (hold_seen != hold_asked) begin
         hold_left = LONG_HOLD;
         hold_seen++;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // predict on accepted text words, check accepted result words
   always @(posedge clock) begin
      utf8_word_type w;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            decode_text_byte(req_tdata, req_tuser, req_tlast);
            n_req_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            n_rsp_taken++;
            if (rsp_tlast) status_seen[rsp_tdata[10:8]]++;
            if (utf8_expected.size() == 0) begin
               $error("result word with nothing expected: tdata %h tuser %b tlast %b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               n_errors++;
            end else begin
               w = utf8_expected.pop_front();
               if (rsp_tdata[7:0] !== w.out_byte) begin
                  $error("out_byte: expected %h, got %h", w.out_byte, rsp_tdata[7:0]);
                  n_errors++;
               end
               if (rsp_tuser !== w.byte_valid) begin
                  $error("byte_valid: expected %b, got %b", w.byte_valid, rsp_tuser);
                  n_errors++;
               end
               if (rsp_tlast !== w.run_last) begin
                  $error("run_last: expected %b, got %b", w.run_last, rsp_tlast);
                  n_errors++;
               end
               if (rsp_tdata[10:8] !== w.status) begin
                  $error("status: expected %0d, got %0d", w.status, rsp_tdata[10:8]);
                  n_errors++;
               end
               if (rsp_tdata[15:11] !== 5'b0) begin
                  $error("tdata padding: expected 00, got %h", rsp_tdata[15:11]);
                  n_errors++;
               end
            end
         end
         // watchdog on cycles with no handshake at all
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: %0d words still expected", utf8_expected.size());
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic queue_byte(input logic [7:0] b, input logic start, input logic eoi,
                             input bit counted);
      text_pending.insert(text_pending.size(),
                          '{data: b, start: start, eoi: eoi, drain_first: 1'b0});
      if (counted) n_words_queued++;
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) queue_byte(s[i], 1'b0, 1'b0, 1'b1);
   endtask

   task automatic queue_hex_escape(input logic [15:0] v);
      queue_byte(jsu_pkg::CH_BACKSLASH, 1'b0, 1'b0, 1'b1);
      queue_byte(jsu_pkg::CH_U, 1'b0, 1'b0, 1'b1);
      for (int i = 3; i >= 0; i--) queue_byte(hex_char(v[4*i +: 4]), 1'b0, 1'b0, 1'b1);
   endtask

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do c = 8'($urandom_range(8'h20, 8'hff));
      while (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BACKSLASH);
      return c;
   endfunction

   // one literal: mostly well formed, sometimes broken in one of many ways
   task automatic queue_random_literal();
      logic [7:0]  c;
      logic [15:0] v;
      logic [7:0]  simple_esc[8];
      int          k;
      simple_esc = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_SLASH,
                     jsu_pkg::CH_B, jsu_pkg::CH_F, jsu_pkg::CH_N, jsu_pkg::CH_R,
                     jsu_pkg::CH_T};
      // idle noise between literals
      if ($urandom_range(3) == 0)
         repeat ($urandom_range(1, 2))
            queue_byte(8'($urandom), 1'b0, 1'($urandom_range(1)), 1'b0);
      if ($urandom_range(39) == 0) begin
         queue_byte(jsu_pkg::CH_QUOTE, 1'b1, 1'b1, 1'b1);
         return;
      end
      queue_byte(jsu_pkg::CH_QUOTE, 1'b1, 1'b0, 1'b1);
      if ($urandom_range(59) == 0) text_pending[text_pending.size() - 1].drain_first = 1'b1;
      repeat ($urandom_range(0, 6)) begin
         case ($urandom_range(9))
            0, 1, 2, 3: queue_byte(plain_char(), 1'b0, 1'b0, 1'b1);
            4, 5: begin
               queue_byte(jsu_pkg::CH_BACKSLASH, 1'b0, 1'b0, 1'b1);
               queue_byte(simple_esc[$urandom_range(7)], 1'b0, 1'b0, 1'b1);
            end
            6: queue_hex_escape(16'($urandom_range(0, 16'h7ff)));
            7: begin
               do v = 16'($urandom_range(16'h800, 16'hffff));
               while (v >= 16'hd800 && v <= 16'hdfff);
               queue_hex_escape(v);
            end
            default: begin
               queue_hex_escape(16'hd800 | 16'($urandom_range(1023)));
               queue_hex_escape(16'hdc00 | 16'($urandom_range(1023)));
            end
         endcase
      end
      case ($urandom_range(19))
         11: begin
            queue_byte(8'($urandom_range(8'h1f)), 1'b0, 1'b0, 1'b1);
         end
         12: begin
            // unknown escape letter, control bytes included
            do c = 8'($urandom);
            while (c inside {jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_SLASH,
                             jsu_pkg::CH_B, jsu_pkg::CH_F, jsu_pkg::CH_N,
                             jsu_pkg::CH_R, jsu_pkg::CH_T, jsu_pkg::CH_U});
            queue_byte(jsu_pkg::CH_BACKSLASH, 1'b0, 1'b0, 1'b1);
            queue_byte(c, 1'b0, 1'b0, 1'b1);
         end
         13: begin
            // bad hex digit in the first or the second escape of a pair
            if ($urandom_range(1)) begin
               queue_hex_escape(16'hd800 | 16'($urandom_range(1023)));
            end
            queue_byte(jsu_pkg::CH_BACKSLASH, 1'b0, 1'b0, 1'b1);
            queue_byte(jsu_pkg::CH_U, 1'b0, 1'b0, 1'b1);
            k = $urandom_range(3);
            repeat (k) queue_byte(hex_char(4'($urandom)), 1'b0, 1'b0, 1'b1);
            do c = 8'($urandom);
            while (nibble_of(c) >= 0);
            queue_byte(c, 1'b0, 1'b0, 1'b1);
         end
         14: queue_hex_escape(16'hdc00 | 16'($urandom_range(1023)));
         15: begin
            // high half not followed by backslash and u
            queue_hex_escape(16'hd800 | 16'($urandom_range(1023)));
            if ($urandom_range(1)) begin
               do c = 8'($urandom);
               while (c == jsu_pkg::CH_BACKSLASH);
            end else begin
               queue_byte(jsu_pkg::CH_BACKSLASH, 1'b0, 1'b0, 1'b1);
               do c = 8'($urandom);
               while (c == jsu_pkg::CH_U);
            end
            queue_byte(c, 1'b0, 1'b0, 1'b1);
         end
         16: begin
            queue_hex_escape(16'hd800 | 16'($urandom_range(1023)));
            do v = 16'($urandom);
            while (v >= 16'hdc00 && v <= 16'hdfff);
            queue_hex_escape(v);
         end
         17: begin
            // input ends inside the literal, on any byte
            queue_byte(8'($urandom), 1'b0, 1'b1, 1'b1);
         end
         18: ; // next start lands while the literal is still open
         19: begin
            do c = 8'($urandom);
            while (c == jsu_pkg::CH_QUOTE);
            queue_byte(c, 1'b1, 1'($urandom_range(1)), 1'b1);
         end
         default: queue_byte(jsu_pkg::CH_QUOTE, 1'b0, ($urandom_range(9) == 0), 1'b1);
      endcase
   endtask

   // wait until the driver has handed over every queued word
   task automatic drain_text();
      while (text_pending.size() != 0 || n_req_taken != n_req_offered) @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: idle byte, extremes, escaped zero, a surrogate pair in
      // mixed case, a control byte, start on a non-quote with end of input
      send_idle_pct = 17;
      recv_idle_pct = 71;
      queue_byte(8'h78, 1'b0, 1'b0, 1'b0);
      queue_byte(jsu_pkg::CH_QUOTE, 1'b1, 1'b0, 1'b1);
      queue_byte(jsu_pkg::CH_SPACE, 1'b0, 1'b0, 1'b1);
      queue_byte(8'hff, 1'b0, 1'b0, 1'b1);
      queue_text("\\u0000\\uD83d\\udE00");
      queue_byte(8'h1f, 1'b0, 1'b0, 1'b1);
      queue_byte(8'h00, 1'b1, 1'b1, 1'b1);
      while (n_words_queued < PHASE_WORDS) queue_random_literal();
      drain_text();

      // sender holds back until every outstanding result has come
      while (utf8_expected.size() != 0) @(posedge clock);

      // sender slow, receiver quick
      send_idle_pct = 71;
      recv_idle_pct = 17;
      while (n_words_queued < 2 * PHASE_WORDS) queue_random_literal();
      drain_text();

      // full rate, opening with a long hold-off on the result side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_asked++;
      while (n_words_queued < 3 * PHASE_WORDS) queue_random_literal();
      drain_text();

      while (utf8_expected.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("%0d text words in, %0d result words checked over three stall patterns",
               n_req_taken, n_rsp_taken);
      $display("final status per byte: run %0d closed %0d ctrl %0d esc %0d hex %0d",
               status_seen[jsu_pkg::ST_RUNNING], status_seen[jsu_pkg::ST_CLOSED],
               status_seen[jsu_pkg::ST_CONTROL], status_seen[jsu_pkg::ST_BAD_ESCAPE],
               status_seen[jsu_pkg::ST_BAD_HEX]);
      $display("  surrogate %0d unterminated %0d idle %0d",
               status_seen[jsu_pkg::ST_BAD_SURR], status_seen[jsu_pkg::ST_UNTERMINATED],
               status_seen[jsu_pkg::ST_IDLE]);
      if (n_errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== json_string_unescaper.f =====
design/jsu_pkg.sv
design/jsu_decode.sv
design/jsu_out.sv
design/json_string_unescaper.sv
tb/sv/json_string_unescaper_tb.sv
